### hdl/crc8pd_pkg.sv
// ----------------------------------------------------------------------------
// crc8pd_pkg
// shared types, constants and the crc-8 byte update for the packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package crc8pd_pkg;

    localparam int PAYLOAD_MAX_DEF = 64;
    localparam int COUNT_W         = 7;
    localparam int IDX_OUT_W       = 6;

    localparam logic [7:0] CRC_POLY_RESET = 8'h07;
    localparam logic [7:0] CRC_INIT       = 8'h00;

    localparam logic       REG_CRC_POLY   = 1'b0;

    typedef enum logic [1:0] {
        STAT_GOOD    = 2'd0,
        STAT_CRC_ERR = 2'd1,
        STAT_LEN_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic    crc_start;
        logic    crc_run;
        logic    cap_addr;
        logic    cap_id;
        logic    cap_len;
        logic    wr_store;
        logic    rd_start;
        logic    rd_next;
        logic    load_out;
        logic    out_from_store;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        logic len_over;
        logic len_zero;
        logic held_len_zero;
        logic data_done;
        logic crc_match;
        logic rd_last;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ poly) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/crc8pd_ctrl.sv
// ----------------------------------------------------------------------------
// crc8pd_ctrl
// frame sequencer: walks the header, payload and crc bytes and drives the
// payload replay from the store
// ----------------------------------------------------------------------------
`default_nettype none

module crc8pd_ctrl
    import crc8pd_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_rx_valid,
    output logic  o_rx_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_ADDR = 7'b0000001,
        S_ID   = 7'b0000010,
        S_LEN  = 7'b0000100,
        S_DATA = 7'b0001000,
        S_CRC  = 7'b0010000,
        S_READ = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   can_take;
    logic   rx_acc;

    always_comb begin
        unique case (r_state)
            S_ADDR, S_ID, S_DATA: can_take = 1'b1;
            S_LEN, S_CRC:         can_take = i_stat.out_free;
            default:              can_take = 1'b0;
        endcase
    end

    assign o_rx_stall = !can_take;
    assign rx_acc     = i_rx_valid && can_take;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_status = STAT_GOOD;
        unique case (r_state)
            S_ADDR: begin
                if (rx_acc) begin
                    o_cmd.crc_start = 1'b1;
                    o_cmd.cap_addr  = 1'b1;
                    n_state         = S_ID;
                end
            end
            S_ID: begin
                if (rx_acc) begin
                    o_cmd.crc_run = 1'b1;
                    o_cmd.cap_id  = 1'b1;
                    n_state       = S_LEN;
                end
            end
            S_LEN: begin
                if (rx_acc) begin
                    o_cmd.crc_run = 1'b1;
                    o_cmd.cap_len = 1'b1;
                    if (i_stat.len_over) begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = STAT_LEN_ERR;
                        n_state          = S_ADDR;
                    end else if (i_stat.len_zero) begin
                        n_state = S_CRC;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (rx_acc) begin
                    o_cmd.crc_run  = 1'b1;
                    o_cmd.wr_store = 1'b1;
                    if (i_stat.data_done) begin
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                if (rx_acc) begin
                    if (!i_stat.crc_match) begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.out_status = STAT_CRC_ERR;
                        n_state          = S_ADDR;
                    end else if (i_stat.held_len_zero) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_ADDR;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out       = 1'b1;
                    o_cmd.out_from_store = 1'b1;
                    if (i_stat.rd_last) begin
                        n_state = S_ADDR;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            default: n_state = S_ADDR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ADDR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### hdl/crc8pd_dpath.sv
// ----------------------------------------------------------------------------
// crc8pd_dpath
// header registers, running crc, payload store and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module crc8pd_dpath
    import crc8pd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_rx_byte,
    input  wire  [7:0]            i_crc_poly,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_res_valid,
    input  wire                   i_res_stall,
    output logic [1:0]            o_status,
    output logic [7:0]            o_dev_address,
    output logic [7:0]            o_message_id,
    output logic [7:0]            o_payload_length,
    output logic [7:0]            o_payload_byte,
    output logic [IDX_OUT_W-1:0]  o_byte_index,
    output logic                  o_last
);

    localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [7:0]         r_addr;
    logic [7:0]         r_id;
    logic [7:0]         r_len;
    logic [COUNT_W-1:0] r_count;
    logic [7:0]         r_crc;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [7:0]         r_rdata;
    logic [7:0]         r_store [PAYLOAD_MAX];

    logic               r_out_valid;
    t_status            r_out_status;
    logic [7:0]         r_out_addr;
    logic [7:0]         r_out_id;
    logic [7:0]         r_out_len;
    logic [7:0]         r_out_byte;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;

    logic [7:0]         rd_next_pos;

    assign rd_next_pos = 8'(r_rd_idx) + 8'd1;

    assign o_stat.len_over      = i_rx_byte > 8'(PAYLOAD_MAX);
    assign o_stat.len_zero      = i_rx_byte == 8'd0;
    assign o_stat.held_len_zero = r_len == 8'd0;
    assign o_stat.data_done     = ({1'b0, r_count} + 8'd1) >= r_len;
    assign o_stat.crc_match     = i_rx_byte == r_crc;
    assign o_stat.rd_last       = rd_next_pos == r_len;
    assign o_stat.out_free      = !r_out_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= CRC_INIT;
            r_count <= '0;
        end else begin
            if (i_cmd.crc_start) begin
                r_crc <= crc8_update(CRC_INIT, i_rx_byte, i_crc_poly);
            end else if (i_cmd.crc_run) begin
                r_crc <= crc8_update(r_crc, i_rx_byte, i_crc_poly);
            end
            if (i_cmd.cap_addr || i_cmd.cap_len) begin
                r_count <= '0;
            end else if (i_cmd.wr_store) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_addr) begin
            r_addr <= i_rx_byte;
        end
        if (i_cmd.cap_id) begin
            r_id <= i_rx_byte;
        end
        if (i_cmd.cap_len) begin
            r_len <= i_rx_byte;
        end
        if (i_cmd.rd_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    // payload store, single write and single registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_store) begin
            r_store[r_count[IDX_W-1:0]] <= i_rx_byte;
        end
        r_rdata <= r_store[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_addr   <= r_addr;
            r_out_id     <= r_id;
            // a length error is loaded in the same cycle the length byte arrives, before r_len holds it
            r_out_len    <= i_cmd.cap_len ? i_rx_byte : r_len;
            if (i_cmd.out_from_store) begin
                r_out_byte <= r_rdata;
                r_out_idx  <= r_rd_idx;
                r_out_last <= o_stat.rd_last;
            end else begin
                r_out_byte <= 8'd0;
                r_out_idx  <= '0;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_dev_address    = r_out_addr;
    assign o_message_id     = r_out_id;
    assign o_payload_length = r_out_len;
    assign o_payload_byte   = r_out_byte;
    assign o_byte_index     = IDX_OUT_W'(r_out_idx);
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

### hdl/crc8_packet_deframer.sv
// results: a status result (length error, crc error, empty good frame) is
//   registered in the cycle after the byte that causes it
// throughput: one byte per cycle while receiving, length and crc bytes wait
//   while a result is held; a good frame replays its payload one result at a
//   time (registered store read, then result load), input stalled meanwhile
// reset: synchronous active low; clears sequencer, crc, result valid, poly 0x07
// ----------------------------------------------------------------------------
// crc8_packet_deframer
// length-prefixed frame receiver with running crc-8 check and payload replay
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_packet_deframer
    import crc8pd_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [0:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  wire                  i_rx_valid,
    output logic                 o_rx_stall,
    input  wire  [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    input  wire                  i_res_stall,
    output logic [1:0]           o_status,
    output logic [7:0]           o_dev_address,
    output logic [7:0]           o_message_id,
    output logic [7:0]           o_payload_length,
    output logic [7:0]           o_payload_byte,
    output logic [IDX_OUT_W-1:0] o_byte_index,
    output logic                 o_last
);

    logic [7:0] r_crc_poly;
    t_cmd       cmd;
    t_stat      stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= CRC_POLY_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_CRC_POLY) begin
            r_crc_poly <= pwdata[7:0];
        end
    end

    always_comb begin
        unique case (paddr)
            REG_CRC_POLY: prdata = {24'd0, r_crc_poly};
            default:      prdata = 32'd0;
        endcase
    end

    crc8pd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    crc8pd_dpath #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_crc_poly       (r_crc_poly),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_status         (o_status),
        .o_dev_address    (o_dev_address),
        .o_message_id     (o_message_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire

### test/crc8pd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8pd_checker
// watches the byte, result and register channels of the packet deframer,
// predicts every result from the accepted bytes and compares them in order
// ----------------------------------------------------------------------------

package crc8pd_tb_pkg;

    function automatic logic [7:0] crc8_next(input logic [7:0] acc,
                                             input logic [7:0] data,
                                             input logic [7:0] gen);
        logic [7:0] r;
        logic       fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ gen;
            end
        end
        return r;
    endfunction

endpackage

module crc8pd_checker
    import crc8pd_pkg::*;
    import crc8pd_tb_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_psel,
    input  wire        i_penable,
    input  wire        i_pwrite,
    input  wire  [0:0] i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire        i_pready,
    input  wire        i_rx_valid,
    input  wire        i_rx_stall,
    input  wire  [7:0] i_rx_byte,
    input  wire        i_res_valid,
    input  wire        i_res_stall,
    input  wire  [1:0] i_status,
    input  wire  [7:0] i_dev_address,
    input  wire  [7:0] i_message_id,
    input  wire  [7:0] i_payload_length,
    input  wire  [7:0] i_payload_byte,
    input  wire  [IDX_OUT_W-1:0] i_byte_index,
    input  wire        i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    typedef enum logic [2:0] {
        RX_ADDR,
        RX_ID,
        RX_LEN,
        RX_DATA,
        RX_CRC
    } t_rx_phase;

    typedef struct {
        t_status              status;
        logic [7:0]           addr;
        logic [7:0]           id;
        logic [7:0]           len;
        logic [7:0]           pbyte;
        logic [IDX_OUT_W-1:0] idx;
        logic                 last;
    } t_frame_result;

    t_frame_result expected_results[$];

    t_rx_phase  rx_phase;
    logic [7:0] poly;
    logic [7:0] held_addr;
    logic [7:0] held_id;
    logic [7:0] held_len;
    logic [6:0] data_count;
    logic [7:0] crc_acc;
    logic [7:0] payload_copy [PAYLOAD_MAX_DEF];
    int         fails;
    int         checked;

    initial begin
        fails        = 0;
        checked      = 0;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic expect_result(input t_status st, input logic [7:0] pb,
                                 input logic [IDX_OUT_W-1:0] ix, input logic lst);
        t_frame_result r;
        r.status = st;
        r.addr   = held_addr;
        r.id     = held_id;
        r.len    = held_len;
        r.pbyte  = pb;
        r.idx    = ix;
        r.last   = lst;
        expected_results.push_back(r);
    endtask

    task automatic back_to_addr();
        rx_phase   = RX_ADDR;
        data_count = '0;
        crc_acc    = CRC_INIT;
    endtask

    task automatic predict_rx_byte(input logic [7:0] b);
        case (rx_phase)
            RX_ADDR: begin
                held_addr  = b;
                crc_acc    = crc8_next(CRC_INIT, b, poly);
                data_count = '0;
                rx_phase   = RX_ID;
            end
            RX_ID: begin
                held_id  = b;
                crc_acc  = crc8_next(crc_acc, b, poly);
                rx_phase = RX_LEN;
            end
            RX_LEN: begin
                held_len   = b;
                crc_acc    = crc8_next(crc_acc, b, poly);
                data_count = '0;
                if (b > PAYLOAD_MAX_DEF) begin
                    expect_result(STAT_LEN_ERR, 8'h00, '0, 1'b1);
                    back_to_addr();
                end else if (b == 8'h00) begin
                    rx_phase = RX_CRC;
                end else begin
                    rx_phase = RX_DATA;
                end
            end
            RX_DATA: begin
                if (data_count < PAYLOAD_MAX_DEF) begin
                    payload_copy[data_count[5:0]] = b;
                end
                crc_acc    = crc8_next(crc_acc, b, poly);
                data_count = data_count + 7'd1;
                if (data_count >= held_len) begin
                    rx_phase = RX_CRC;
                end
            end
            default: begin
                if (rx_phase == RX_CRC && b == crc_acc) begin
                    if (held_len == 8'h00) begin
                        expect_result(STAT_GOOD, 8'h00, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < held_len && i < PAYLOAD_MAX_DEF; i++) begin
                            expect_result(STAT_GOOD, payload_copy[i], IDX_OUT_W'(i),
                                          (i + 1 == held_len));
                        end
                    end
                end else begin
                    expect_result(STAT_CRC_ERR, 8'h00, '0, 1'b1);
                end
                back_to_addr();
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result e;
        if (!i_rst_n) begin
            poly      = CRC_POLY_RESET;
            held_addr = '0;
            held_id   = '0;
            held_len  = '0;
            back_to_addr();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == REG_CRC_POLY) begin
                poly = i_pwdata[7:0];
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: status %0h index %0h",
                           i_status, i_byte_index);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", 8'(e.status), 8'(i_status));
                    check_field("dev_address", e.addr, i_dev_address);
                    check_field("message_id", e.id, i_message_id);
                    check_field("payload_length", e.len, i_payload_length);
                    check_field("payload_byte", e.pbyte, i_payload_byte);
                    check_field("byte_index", 8'(e.idx), 8'(i_byte_index));
                    check_field("last", 8'(e.last), 8'(i_last));
                    checked++;
                end
            end
            if (i_rx_valid && !i_rx_stall) begin
                predict_rx_byte(i_rx_byte);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives framed byte streams into the packet deframer under varying idle
// and stall patterns and polynomial settings; the checker judges results
// ----------------------------------------------------------------------------

module testbench;
    import crc8pd_pkg::*;
    import crc8pd_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 135;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [0:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        i_rx_valid  = 1'b0;
    wire         o_rx_stall;
    logic [7:0]  i_rx_byte   = '0;
    wire         o_res_valid;
    logic        i_res_stall = 1'b0;
    wire  [1:0]  o_status;
    wire  [7:0]  o_dev_address;
    wire  [7:0]  o_message_id;
    wire  [7:0]  o_payload_length;
    wire  [7:0]  o_payload_byte;
    wire  [IDX_OUT_W-1:0] o_byte_index;
    wire         o_last;

    int         fail_count;
    int         pending;
    int         checked;
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    bit         hold_req     = 1'b0;
    int         quiet_cycles = 0;
    int         bytes_sent   = 0;
    int         frames_sent  = 0;
    int         frames_bad   = 0;
    int         frames_over  = 0;
    int         noise_runs   = 0;
    logic [7:0] cur_poly     = CRC_POLY_RESET;

    crc8_packet_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_status         (o_status),
        .o_dev_address    (o_dev_address),
        .o_message_id     (o_message_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_last           (o_last)
    );

    crc8pd_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .i_rx_valid       (i_rx_valid),
        .i_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .i_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .i_status         (o_status),
        .i_dev_address    (o_dev_address),
        .i_message_id     (o_message_id),
        .i_payload_length (o_payload_length),
        .i_payload_byte   (o_payload_byte),
        .i_byte_index     (o_byte_index),
        .i_last           (o_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_res_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rx_valid && !o_rx_stall) || (o_res_valid && !i_res_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("status: fail");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic put_tracked(input logic [7:0] b, inout logic [7:0] acc);
        put_byte(b);
        acc = crc8_next(acc, b, cur_poly);
    endtask

    // fill below zero gives random payload bytes
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] id,
                              input logic [7:0] len, input int fill, input bit corrupt);
        logic [7:0] acc;
        logic [7:0] pb;
        acc = CRC_INIT;
        frames_sent++;
        put_tracked(addr, acc);
        put_tracked(id, acc);
        put_tracked(len, acc);
        if (len > PAYLOAD_MAX_DEF) begin
            frames_over++;
            return;
        end
        for (int i = 0; i < len; i++) begin
            pb = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            put_tracked(pb, acc);
        end
        if (corrupt) begin
            frames_bad++;
            put_byte(acc ^ 8'($urandom_range(1, 255)));
        end else begin
            put_byte(acc);
        end
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] poly);
        logic [31:0] w;
        w       = $urandom();
        w[7:0]  = poly;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CRC_POLY;
        pwdata  <= w;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cur_poly = poly;
    endtask

    initial begin
        logic [7:0] acc;
        logic [7:0] poly_set [3];
        int         r;
        int         goal;

        poly_set[0] = 8'h00;
        poly_set[1] = 8'h80 | 8'($urandom_range(0, 127));
        poly_set[2] = CRC_POLY_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct  = 9;
        rx_stall_pct = 60;

        // empty frame, single byte, bad crc, oversize lengths
        send_frame(8'h00, 8'hFF, 8'd0, 0, 1'b0);
        send_frame(8'hFF, 8'h00, 8'd1, 8'hFF, 1'b0);
        send_frame(8'h81, 8'h7E, 8'd2, 8'h00, 1'b1);
        send_frame(8'h12, 8'h34, 8'd65, -1, 1'b0);
        send_frame(8'hAB, 8'hCD, 8'd255, -1, 1'b0);

        // polynomial changed between header and length byte
        drain();
        acc = CRC_INIT;
        frames_sent++;
        put_tracked(8'h5A, acc);
        put_tracked(8'hC3, acc);
        drain();
        cfg_write(8'hFF);
        put_tracked(8'd3, acc);
        repeat (3) put_tracked(8'($urandom_range(0, 255)), acc);
        put_byte(acc);
        drain();

        for (int p = 0; p < 3; p++) begin
            tx_idle_pct  = (p == 0) ? 9 : (p == 1) ? 60 : 0;
            rx_stall_pct = (p == 0) ? 60 : (p == 1) ? 9 : 0;
            drain();
            cfg_write(poly_set[p]);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            if (p == 2) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'(PAYLOAD_MAX_DEF), -1, 1'b0);
            end
            goal = bytes_sent + PHASE_BYTES;
            while (bytes_sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    // stray bytes knock the stream out of frame alignment
                    noise_runs++;
                    repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
                end else if (r < 14) begin
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(65, 255)), -1, 1'b0);
                end else if (r < 17) begin
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(33, 64)), -1,
                               ($urandom_range(0, 99) < 12));
                end else begin
                    send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 8)), -1,
                               ($urandom_range(0, 99) < 12));
                end
            end
        end
        drain();

        $display("sent %0d bytes in %0d frames (%0d corrupted, %0d oversize, %0d noise runs)",
                 bytes_sent, frames_sent, frames_bad, frames_over, noise_runs);
        $display("checked %0d results over four polynomials, three idle profiles, one hold-off",
                 checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
